/* rtl/triangle_cull_viewport_unit_defines.svh */
// assertion helpers for the triangle unit
`ifndef TRIANGLE_CULL_VIEWPORT_UNIT_DEFINES_SVH
`define TRIANGLE_CULL_VIEWPORT_UNIT_DEFINES_SVH

// same-cycle implication
`define TCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tcv_pkg.sv */
package tcv_pkg;
  localparam int FRAC = 16;
  localparam int CW = 32;
  localparam int QW = CW + FRAC;
  localparam int DIV_LAT = QW + 1;
  localparam int TW = 48;
  localparam int RW = 13;

  localparam logic [1:0] ST_DRAWN = 2'd0;
  localparam logic [1:0] ST_CULLED = 2'd1;
  localparam logic [1:0] ST_WZERO = 2'd2;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [RW-1:0] WIDTH_RST = RW'(640);
  localparam logic [RW-1:0] HEIGHT_RST = RW'(480);

  // truncate t / 2^(FRAC+1) toward zero, saturate to 16 bits
  function automatic logic signed [15:0] to_screen(input logic signed [TW-1:0] t);
    logic signed [TW-1:0] q;
    q = t >>> (FRAC + 1);
    if (t[TW-1] && (t[FRAC:0] != '0)) q = q + TW'(1);
    if (q > TW'(32767)) to_screen = 16'sh7fff;
    else if (q < -TW'(32768)) to_screen = 16'sh8000;
    else to_screen = q[15:0];
  endfunction
endpackage

/* rtl/triangle_cull_viewport_unit.sv */
// one triangle per cycle unless a stalled result holds the pipeline
// the divide is a 48-step restoring divider pipeline per coordinate
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// rst is synchronous and clears valid bits; width resets to 640, height to 480
`include "triangle_cull_viewport_unit_defines.svh"
module triangle_cull_viewport_unit import tcv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [RW-1:0]      cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] v0_x, v0_y, v0_z, v0_w,
  input  logic signed [31:0] v1_x, v1_y, v1_z, v1_w,
  input  logic signed [31:0] v2_x, v2_y, v2_z, v2_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [15:0] s0_x, s0_y,
  output logic signed [31:0] d0_z,
  output logic signed [15:0] s1_x, s1_y,
  output logic signed [31:0] d1_z,
  output logic signed [15:0] s2_x, s2_y,
  output logic signed [31:0] d2_z
);
  logic en;
  logic [RW-1:0] scr_w, scr_h;
  logic signed [CW-1:0] cin [0:8];
  logic signed [CW-1:0] win [0:2];
  logic signed [CW-1:0] nv [0:8];
  logic vp [0:DIV_LAT];
  logic wz [0:DIV_LAT];

  logic v2r, wz2, v3r, wz3;
  logic signed [CW:0] dx1, dy1, dx2, dy2;
  logic signed [45:0] px [0:2];
  logic signed [45:0] py [0:2];
  logic signed [CW-1:0] nz2 [0:2];
  logic signed [CW-1:0] nz3 [0:2];
  logic signed [65:0] cp, cq;
  logic signed [TW-1:0] tx [0:2];
  logic signed [TW-1:0] ty [0:2];
  logic signed [13:0] wv, hv;
  logic               culled;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= WIDTH_RST;
      scr_h <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  scr_w <= cfg_data;
        REG_HEIGHT: scr_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) vp[0] <= 1'b0;
    else if (en) vp[0] <= in_valid;
    if (en) begin
      cin[0] <= v0_x; cin[1] <= v0_y; cin[2] <= v0_z;
      cin[3] <= v1_x; cin[4] <= v1_y; cin[5] <= v1_z;
      cin[6] <= v2_x; cin[7] <= v2_y; cin[8] <= v2_z;
      win[0] <= v0_w; win[1] <= v1_w; win[2] <= v2_w;
    end
  end
  assign wz[0] = (win[0] == '0) || (win[1] == '0) || (win[2] == '0);

  for (genvar k = 0; k < 9; k++) begin : g_div
    logic [CW-1:0] cm, wm;
    assign cm = cin[k][CW-1] ? CW'(-cin[k]) : CW'(cin[k]);
    assign wm = win[k/3][CW-1] ? CW'(-win[k/3]) : CW'(win[k/3]);
    tcv_div u_div (
      .clk     (clk),
      .en      (en),
      .num_mag ({cm, FRAC'(0)}),
      .den     (wm),
      .neg     (cin[k][CW-1] ^ win[k/3][CW-1]),
      .q       (nv[k])
    );
  end

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_meta
    always_ff @(posedge clk) begin
      if (rst) vp[i+1] <= 1'b0;
      else if (en) vp[i+1] <= vp[i];
      if (en) wz[i+1] <= wz[i];
    end
  end

  assign wv = {1'b0, scr_w};
  assign hv = {1'b0, scr_h};

  // edge differences and viewport scaling
  always_ff @(posedge clk) begin
    if (rst) v2r <= 1'b0;
    else if (en) v2r <= vp[DIV_LAT];
    if (en) begin
      wz2 <= wz[DIV_LAT];
      dx1 <= (CW+1)'(nv[3]) - (CW+1)'(nv[0]);
      dy1 <= (CW+1)'(nv[4]) - (CW+1)'(nv[1]);
      dx2 <= (CW+1)'(nv[6]) - (CW+1)'(nv[0]);
      dy2 <= (CW+1)'(nv[7]) - (CW+1)'(nv[1]);
      for (int k = 0; k < 3; k++) begin
        px[k]  <= wv * nv[3*k];
        py[k]  <= hv * nv[3*k+1];
        nz2[k] <= nv[3*k+2];
      end
    end
  end

  // cross product terms and offsets
  always_ff @(posedge clk) begin
    if (rst) v3r <= 1'b0;
    else if (en) v3r <= v2r;
    if (en) begin
      wz3 <= wz2;
      cp <= dx1 * dy2;
      cq <= dy1 * dx2;
      for (int k = 0; k < 3; k++) begin
        tx[k]  <= TW'(px[k]) + signed'(TW'(scr_w) << FRAC);
        ty[k]  <= signed'(TW'(scr_h) << FRAC) - TW'(py[k]);
        nz3[k] <= nz2[k];
      end
    end
  end

  assign culled = cp < cq;

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v3r;
    if (en) begin
      if (wz3 || culled) begin
        status <= wz3 ? ST_WZERO : ST_CULLED;
        s0_x <= '0; s0_y <= '0; d0_z <= '0;
        s1_x <= '0; s1_y <= '0; d1_z <= '0;
        s2_x <= '0; s2_y <= '0; d2_z <= '0;
      end else begin
        status <= ST_DRAWN;
        s0_x <= to_screen(tx[0]); s0_y <= to_screen(ty[0]); d0_z <= nz3[0];
        s1_x <= to_screen(tx[1]); s1_y <= to_screen(ty[1]); d1_z <= nz3[1];
        s2_x <= to_screen(tx[2]); s2_y <= to_screen(ty[2]); d2_z <= nz3[2];
      end
    end
  end

  `TCV_ASSERT_NOW(a_status_code, out_valid, status == ST_DRAWN || status == ST_CULLED || status == ST_WZERO, "bad status code")
  `TCV_ASSERT_NOW(a_reject_zero, out_valid && status != ST_DRAWN, s0_x == 0 && s1_y == 0 && d2_z == 0, "rejected triangle carries data")
  `TCV_ASSERT_NEXT(a_stall_freeze, out_valid && out_stall, out_valid && $stable(status) && $stable(d0_z), "stalled result changed")
endmodule

/* rtl/tcv_div.sv */
module tcv_div import tcv_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [QW-1:0]        num_mag,
  input  logic [CW-1:0]        den,
  input  logic                 neg,
  output logic signed [CW-1:0] q
);
  logic [CW-1:0] rem [0:QW];
  logic [QW-1:0] quo [0:QW];
  logic [CW-1:0] dn  [0:QW];
  logic          ng  [0:QW];
  logic [QW-1:0] qm;

  assign rem[0] = '0;
  assign quo[0] = num_mag;
  assign dn[0]  = den;
  assign ng[0]  = neg;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;
    assign trial = {rem[i], quo[i][QW-1]};
    assign diff  = trial - {1'b0, dn[i]};
    assign ge    = trial >= {1'b0, dn[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
        quo[i+1] <= {quo[i][QW-2:0], ge};
        dn[i+1]  <= dn[i];
        ng[i+1]  <= ng[i];
      end
    end
  end

  assign qm = quo[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (!ng[QW] && qm > QW'(32'h7fffffff)) q <= 32'sh7fffffff;
      else if (ng[QW] && qm > QW'(33'h80000000)) q <= 32'sh80000000;
      else if (ng[QW]) q <= signed'(CW'(-qm));
      else q <= signed'(qm[CW-1:0]);
    end
  end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
  import tcv_pkg::*;

  typedef struct {
    logic signed [31:0] c [12];
  } tri_item_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] sx [3];
    logic signed [15:0] sy [3];
    logic signed [31:0] dz [3];
  } screen_tri_t;

  class viewport_scoreboard;
    screen_tri_t pending [$];
    logic [RW-1:0] width_px;
    logic [RW-1:0] height_px;
    int errors;
    int n_drawn;
    int n_culled;
    int n_wzero;
    int n_checked;

    function void set_viewport(logic [RW-1:0] w, logic [RW-1:0] h);
      width_px = w;
      height_px = h;
    endfunction

    function longint ndc_div(logic signed [31:0] c, logic signed [31:0] w);
      longint q;
      q = (longint'(c) * 65536) / longint'(w);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function logic signed [15:0] screen_coord(longint t);
      longint q;
      q = t / 131072;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_input(tri_item_t t);
      screen_tri_t e;
      longint nx [3];
      longint ny [3];
      longint nz [3];
      logic signed [71:0] a, b, c, d, p, q;
      longint wv, hv;
      e.status = ST_DRAWN;
      for (int k = 0; k < 3; k++) begin
        e.sx[k] = '0;
        e.sy[k] = '0;
        e.dz[k] = '0;
      end
      if (t.c[3] == 0 || t.c[7] == 0 || t.c[11] == 0) begin
        e.status = ST_WZERO;
        n_wzero++;
        pending.insert(pending.size(), e);
        return;
      end
      for (int k = 0; k < 3; k++) begin
        nx[k] = ndc_div(t.c[4*k], t.c[4*k+3]);
        ny[k] = ndc_div(t.c[4*k+1], t.c[4*k+3]);
        nz[k] = ndc_div(t.c[4*k+2], t.c[4*k+3]);
      end
      a = nx[1] - nx[0];
      b = ny[2] - ny[0];
      c = ny[1] - ny[0];
      d = nx[2] - nx[0];
      p = a * b;
      q = c * d;
      if (p < q) begin
        e.status = ST_CULLED;
        n_culled++;
        pending.insert(pending.size(), e);
        return;
      end
      wv = width_px;
      hv = height_px;
      for (int k = 0; k < 3; k++) begin
        e.sx[k] = screen_coord(wv * nx[k] + wv * 65536);
        e.sy[k] = screen_coord(hv * 65536 - hv * ny[k]);
        e.dz[k] = nz[k][31:0];
      end
      n_drawn++;
      pending.insert(pending.size(), e);
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(screen_tri_t r);
      screen_tri_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction, status %0d", $time, r.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (r.status !== e.status) report("status", e.status, r.status);
      for (int k = 0; k < 3; k++) begin
        if (r.sx[k] !== e.sx[k]) report($sformatf("s%0d_x", k), e.sx[k], r.sx[k]);
        if (r.sy[k] !== e.sy[k]) report($sformatf("s%0d_y", k), e.sy[k], r.sy[k]);
        if (r.dz[k] !== e.dz[k]) report($sformatf("d%0d_z", k), e.dz[k], r.dz[k]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_WIDTH;
  logic [RW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] v0_x = 0, v0_y = 0, v0_z = 0, v0_w = 0;
  logic signed [31:0] v1_x = 0, v1_y = 0, v1_z = 0, v1_w = 0;
  logic signed [31:0] v2_x = 0, v2_y = 0, v2_z = 0, v2_w = 0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [15:0] s0_x, s0_y, s1_x, s1_y, s2_x, s2_y;
  logic signed [31:0] d0_z, d1_z, d2_z;

  viewport_scoreboard sb;
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  triangle_cull_viewport_unit DUT (.*);

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // result side: random stall, one long hold-off on request
  initial begin
    int hold;
    screen_tri_t r;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        r.status = status;
        r.sx = '{s0_x, s1_x, s2_x};
        r.sy = '{s0_y, s1_y, s2_y};
        r.dz = '{d0_z, d1_z, d2_z};
        sb.check_result(r);
        hold = draw_gap();
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("%0t: watchdog expired", $time);
      $display("triangle_cull_viewport_unit test failed");
      $finish;
    end
  end

  task automatic send_triangle(tri_item_t t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {v0_x, v0_y, v0_z, v0_w} <= {t.c[0], t.c[1], t.c[2], t.c[3]};
    {v1_x, v1_y, v1_z, v1_w} <= {t.c[4], t.c[5], t.c[6], t.c[7]};
    {v2_x, v2_y, v2_z, v2_w} <= {t.c[8], t.c[9], t.c[10], t.c[11]};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_viewport(logic [RW-1:0] w, logic [RW-1:0] h);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_viewport(w, h);
  endtask

  function automatic tri_item_t make_tri(int sel, int wmag);
    tri_item_t t;
    for (int k = 0; k < 3; k++) begin
      int w;
      w = $urandom_range(32768, wmag);
      if ($urandom_range(0, 15) == 0) w = -w;
      t.c[4*k+3] = w;
      for (int j = 0; j < 3; j++)
        t.c[4*k+j] = $signed($urandom_range(0, 4 * wmag)) - 2 * wmag;
    end
    case (sel)
      0: for (int i = 0; i < 12; i++) t.c[i] = $urandom;
      1: t.c[4 * $urandom_range(0, 2) + 3] = 0;
      2: for (int i = 0; i < 12; i++)
           if ($urandom_range(0, 2) == 0)
             t.c[i] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: for (int i = 0; i < 12; i++)
           if (i % 4 == 3) t.c[i] = $signed($urandom_range(0, 6)) - 3;
      default: ;
    endcase
    return t;
  endfunction

  function automatic tri_item_t fixed_tri(logic signed [31:0] x0, y0, x1, y1, x2, y2,
                                          logic signed [31:0] zz, ww);
    tri_item_t t;
    t.c = '{x0, y0, zz, ww, x1, y1, zz, ww, x2, y2, zz, ww};
    return t;
  endfunction

  initial begin
    logic signed [31:0] one, mx, mn;
    tri_item_t t;
    int sel;
    sb = new();
    sb.set_viewport(WIDTH_RST, HEIGHT_RST);
    one = 32'sh10000;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_triangle(fixed_tri(0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(fixed_tri(-one, -one, one, -one, 0, one, one / 2, one));
    send_triangle(fixed_tri(-one, -one, 0, one, one, -one, one / 2, one));
    send_triangle(fixed_tri(0, 0, one, one, 2 * one, 2 * one, 0, one));
    send_triangle(fixed_tri(one, one, one, one, one, one, mx, one));
    send_triangle(fixed_tri(mn, mn, mx, mn, 0, mx, mn, one));
    send_triangle(fixed_tri(mn, mn, mx, mn, 0, mx, mn, -1));
    send_triangle(fixed_tri(mn, mx, mx, mx, mn, mn, mx, 1));
    send_triangle(fixed_tri(-one, -one, one, -one, 0, one, one, mn));
    send_triangle(fixed_tri(-one, -one, one, -one, 0, one, one, mx));
    send_triangle(fixed_tri(-one, -one, one, -one, 0, one, -one, -one));
    t = fixed_tri(-one, -one, one, -one, 0, one, one, one);
    t.c[11] = 0;
    send_triangle(t);
    t.c[11] = one;
    t.c[7] = 0;
    send_triangle(t);
    t = fixed_tri(-3 * one, 2 * one, 5 * one, -one, one, 7 * one, -one, one);
    send_triangle(t);

    // random phases across viewport settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_viewport(13'd1, 13'd1);
        2: write_viewport(13'd4096, 13'd4096);
        3: write_viewport(13'd8191, 13'd0);
        4: write_viewport(13'd0, 13'd8191);
        5: write_viewport(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
        default: ;
      endcase
      for (int i = 0; i < 140; i++) begin
        quiet = (i >= 40 && i < 70);
        if (ph == 2 && i == 80) long_hold_req = 1'b1;
        sel = $urandom_range(0, 19);
        if (sel < 13)
          t = make_tri(9, $urandom_range(0, 1) ? 131072 : 8388608);
        else
          t = make_tri(sel - 13 < 4 ? sel - 13 : 0, 262144);
        send_triangle(t);
      end
    end
    quiet = 1'b0;
    wait_drained();

    $display("checked %0d triangles: %0d drawn, %0d culled, %0d with zero w",
             sb.n_checked, sb.n_drawn, sb.n_culled, sb.n_wzero);
    $display("six viewport settings including zero and 13-bit maximum, random stalls");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("triangle_cull_viewport_unit test passed");
    else
      $display("triangle_cull_viewport_unit test failed");
    $finish;
  end
endmodule
